// ===== src/sad_pkg.sv =====
// sad_pkg: shared types, constants and the table generator for the sigmoid unit
// depends on nothing; used by sad_front, sad_fifo, sad_back and the top level
`timescale 1ns / 1ps
`default_nettype none

package sad_pkg;

    // fraction bits of the table position, Q4.12 input scaled by steps / 8
    localparam int FRAC_W = 15;
    localparam int Y_W    = 16;

    localparam logic [FRAC_W:0]  ROUND_HALF = (FRAC_W + 1)'(1 << (FRAC_W - 1));
    localparam logic [Y_W:0]     ONE_Q16    = (Y_W + 1)'(1 << Y_W);
    localparam logic [Y_W:0]     Y_MAX      = (Y_W + 1)'((1 << Y_W) - 1);
    localparam logic [2*Y_W:0]   DER_ROUND  = (2 * Y_W + 1)'(1 << (Y_W - 1));

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic {
        KIND_VALUE = 1'b0,
        KIND_DERIV = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  neg;
        logic  at_end;
    } t_ctl;

    // round(65536 * sigmoid(t)) saturated; evaluated at elaboration only
    function automatic int sig_q16(real t);
        real e_neg;
        real den;
        real y;
        int  v;
        e_neg = $exp(-t);
        den   = 1.0 + e_neg;
        y     = 0.75;
        // newton reciprocal, error squares each pass
        for (int i = 0; i < 8; i++) begin
            y = y * (2.0 - den * y);
        end
        v = $rtoi(65536.0 * y + 0.5);
        if (v > 65535) begin
            v = 65535;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/sad_front.sv =====
// sad_front: classifies one request into sign, table index and fraction
// depends on sad_pkg
`timescale 1ns / 1ps
`default_nettype none

module sad_front #(
    parameter int TABLE_STEPS = 256
) (
    input  wire logic                             i_kind,
    input  wire logic signed [15:0]               i_x_in,
    output sad_pkg::t_ctl                         o_ctl,
    output logic [$clog2(TABLE_STEPS)-1:0]        o_idx,
    output logic [sad_pkg::FRAC_W-1:0]            o_frac
);

    localparam int KW = $clog2(TABLE_STEPS + 1);
    localparam int IW = $clog2(TABLE_STEPS);
    localparam int PW = sad_pkg::FRAC_W + KW;
    localparam logic [PW-1:0] STEPS_P = PW'(TABLE_STEPS);
    localparam logic [KW-1:0] STEPS_K = KW'(TABLE_STEPS);

    logic          w_neg;
    logic [15:0]   w_mag;
    logic [PW-1:0] w_pos;
    logic [KW-1:0] w_k;
    logic          w_end;

    // magnitude never exceeds 8.0, the most negative code maps to exactly 8.0
    assign w_neg = i_x_in[15];
    assign w_mag = w_neg ? (~i_x_in + 16'd1) : i_x_in;
    assign w_pos = PW'(w_mag) * STEPS_P;
    assign w_k   = w_pos[PW-1:sad_pkg::FRAC_W];
    assign w_end = (w_k == STEPS_K);

    assign o_ctl.kind   = i_kind ? sad_pkg::KIND_DERIV : sad_pkg::KIND_VALUE;
    assign o_ctl.neg    = w_neg;
    assign o_ctl.at_end = w_end;
    assign o_idx        = w_end ? '0 : w_k[IW-1:0];
    assign o_frac       = w_pos[sad_pkg::FRAC_W-1:0];

endmodule

`default_nettype wire

// ===== src/sad_fifo.sv =====
// sad_fifo: short show-ahead queue between the classify front and the back pipeline
// depends on sad_pkg for depth and pointer widths
`timescale 1ns / 1ps
`default_nettype none

module sad_fifo #(
    parameter int W = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [W-1:0]  i_data,
    output logic               o_full,
    output logic               o_valid,
    input  wire logic          i_pop,
    output logic [W-1:0]       o_data,
    output logic [sad_pkg::QCNT_W-1:0] o_count
);

    logic [W-1:0]                 r_mem [sad_pkg::QUEUE_DEPTH];
    logic [sad_pkg::QPTR_W-1:0]   r_wr;
    logic [sad_pkg::QPTR_W-1:0]   r_rd;
    logic [sad_pkg::QCNT_W-1:0]   r_cnt;
    logic [sad_pkg::QCNT_W-1:0]   n_cnt;

    assign o_full  = (r_cnt == sad_pkg::QCNT_W'(sad_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/sad_back.sv =====
// sad_back: table lookup, interpolation, sign fold and derivative, four stages
// depends on sad_pkg; the table is built at elaboration from TABLE_STEPS
`timescale 1ns / 1ps
`default_nettype none

module sad_back #(
    parameter int TABLE_STEPS = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire sad_pkg::t_ctl                 i_ctl,
    input  wire logic [$clog2(TABLE_STEPS)-1:0] i_idx,
    input  wire logic [sad_pkg::FRAC_W-1:0]    i_frac,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [sad_pkg::Y_W-1:0]            o_y_out
);

    localparam int  YW    = sad_pkg::Y_W;
    localparam int  FW    = sad_pkg::FRAC_W;
    localparam int  MW    = YW + FW + 1;
    localparam real TSTEP = 8.0 / TABLE_STEPS;
    localparam int  TAB_END = sad_pkg::sig_q16(8.0);

    logic [YW-1:0] w_rom_lo [TABLE_STEPS];
    logic [YW-1:0] w_rom_dl [TABLE_STEPS];

    // each entry keeps the value and the step to the next one, so one read per item
    for (genvar g = 0; g < TABLE_STEPS; g++) begin : g_rom
        localparam int LO = sad_pkg::sig_q16(real'(g) * TSTEP);
        localparam int HI = sad_pkg::sig_q16(real'(g + 1) * TSTEP);
        localparam int DL = (HI > LO) ? (HI - LO) : 0;
        assign w_rom_lo[g] = YW'(LO);
        assign w_rom_dl[g] = YW'(DL);
    end

    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    logic          r_v1, r_v2, r_v3;
    sad_pkg::t_ctl r1_ctl, r2_ctl, r3_ctl;
    logic [YW-1:0] r1_lo, r1_dl, r2_lo, r3_s;
    logic [FW-1:0] r1_frac;
    logic [MW-1:0] r2_prod;
    logic [YW-1:0] r_y;
    logic          r_v4;

    logic [YW-1:0]   n_lo, n_dl, n_s, n_y;
    logic [MW-1:0]   n_prod;
    logic [YW:0]     w_v, w_vc, w_neg_s;
    logic [2*YW:0]   w_der;

    // a stage moves when it is empty or the one after it moves
    assign w_rdy4  = !r_v4 || !i_stall;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_stall = !w_rdy1;

    assign n_lo = i_ctl.at_end ? YW'(TAB_END) : w_rom_lo[i_idx];
    assign n_dl = i_ctl.at_end ? '0 : w_rom_dl[i_idx];

    assign n_prod = MW'(r1_dl) * MW'(r1_frac) + MW'(sad_pkg::ROUND_HALF);

    assign w_v     = (YW + 1)'(r2_lo) + (YW + 1)'(r2_prod[MW-1:FW]);
    assign w_vc    = (w_v > sad_pkg::Y_MAX) ? sad_pkg::Y_MAX : w_v;
    assign w_neg_s = sad_pkg::ONE_Q16 - w_vc;
    assign n_s     = r2_ctl.neg
                   ? ((w_neg_s > sad_pkg::Y_MAX) ? YW'(sad_pkg::Y_MAX) : w_neg_s[YW-1:0])
                   : w_vc[YW-1:0];

    assign w_der = (2 * YW + 1)'(r3_s) * (2 * YW + 1)'(sad_pkg::ONE_Q16 - (YW + 1)'(r3_s))
                 + sad_pkg::DER_ROUND;
    assign n_y   = (r3_ctl.kind == sad_pkg::KIND_DERIV) ? w_der[2*YW-1:YW] : r3_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r1_ctl  <= i_ctl;
            r1_lo   <= n_lo;
            r1_dl   <= n_dl;
            r1_frac <= i_frac;
        end
        if (w_rdy2 && r_v1) begin
            r2_ctl  <= r1_ctl;
            r2_lo   <= r1_lo;
            r2_prod <= n_prod;
        end
        if (w_rdy3 && r_v2) begin
            r3_ctl <= r2_ctl;
            r3_s   <= n_s;
        end
        if (w_rdy4 && r_v3) begin
            r_y <= n_y;
        end
    end

    assign o_valid = r_v4;
    assign o_y_out = r_y;

endmodule

`default_nettype wire

// ===== src/sigmoid_and_derivative_unit.sv =====
// sigmoid_and_derivative_unit: logistic sigmoid or its derivative, Q4.12 in, Q0.16 out
// depends on sad_pkg, sad_front, sad_fifo and sad_back
//
// Input channel: i_valid / o_stall with i_kind and i_x_in; a request is taken on an
// edge where i_valid is high and o_stall is low. i_kind low returns sigmoid(x), high
// returns s*(1-s).
// Output channel: o_valid / i_stall with o_y_out; a result leaves on an edge where
// o_valid is high and i_stall is low. One result per request, in request order.
// Throughput is one request per cycle while nothing stalls. A request passes through the
// 4-entry queue, then lookup, interpolation multiply, sign fold and derivative multiply
// into the output register.
// When the receiver holds i_stall, the back pipeline fills, then the queue; o_stall
// rises once the queue holds 4 requests. The output holds its result while stalled.
// Reset (synchronous, active low) empties the queue and the pipeline; the lookup
// table is constant logic built at elaboration from TABLE_STEPS.
`timescale 1ns / 1ps
`default_nettype none

module sigmoid_and_derivative_unit #(
    parameter int TABLE_STEPS = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_kind,
    input  wire logic signed [15:0] i_x_in,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [15:0]             o_y_out
);

    localparam int IW = $clog2(TABLE_STEPS);
    localparam int FW = sad_pkg::FRAC_W;
    localparam int CW = $bits(sad_pkg::t_ctl);
    localparam int QW = CW + IW + FW;

    sad_pkg::t_ctl             w_ctl, w_q_ctl;
    logic [IW-1:0]             w_idx, w_q_idx;
    logic [FW-1:0]             w_frac, w_q_frac;
    logic [QW-1:0]             w_q_data;
    logic                      w_push, w_full, w_q_valid, w_back_stall, w_pop;
    logic [sad_pkg::QCNT_W-1:0] w_q_cnt;

    sad_front #(.TABLE_STEPS(TABLE_STEPS)) u_front (
        .i_kind (i_kind),
        .i_x_in (i_x_in),
        .o_ctl  (w_ctl),
        .o_idx  (w_idx),
        .o_frac (w_frac)
    );

    assign w_push  = i_valid && !w_full;
    assign o_stall = w_full;
    assign w_pop   = w_q_valid && !w_back_stall;

    sad_fifo #(.W(QW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_ctl, w_idx, w_frac}),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_count (w_q_cnt)
    );

    assign w_q_ctl  = w_q_data[QW-1:IW+FW];
    assign w_q_idx  = w_q_data[IW+FW-1:FW];
    assign w_q_frac = w_q_data[FW-1:0];

    sad_back #(.TABLE_STEPS(TABLE_STEPS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_stall (w_back_stall),
        .i_ctl   (w_q_ctl),
        .i_idx   (w_q_idx),
        .i_frac  (w_q_frac),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_y_out (o_y_out)
    );

    // a taken request always leaves something in the queue on the next cycle
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (w_q_cnt != '0))
        else $error("queue empty after a request was taken");

    // back pressure only appears after a request was pushed
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(i_valid))
        else $error("o_stall rose without a pushed request");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
